// ===== rtl/ufg_pkg.sv =====
// Package for the UDP frame train generator.
// Holds the phase encoding, register indexes and protocol constants.
// No dependencies.
package ufg_pkg;

	localparam int unsigned ADDR_W = 6;
	localparam int unsigned HDR_WORDS = 8;

	localparam logic [15:0] MIN_FRAME_LEN = 16'd60;
	localparam logic [15:0] MAC_HDR_LEN = 16'd14;
	localparam logic [15:0] ALL_HDR_LEN = 16'd34;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [7:0] IP_TOS = 8'h00;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_GAP
	} phase_t;

	typedef enum logic [2:0] {
		REG_DEST_MAC,
		REG_SRC_MAC,
		REG_IP_ADDRESSES,
		REG_UDP_PORTS,
		REG_FRAME_LENGTH,
		REG_ID_FLAGS_TTL,
		REG_PACKET_COUNT,
		REG_GAP_TICKS
	} reg_idx_t;

endpackage

// ===== rtl/udp_frame_train_generator.sv =====
// Top level of the UDP frame train generator: register file, train sequencer and
// header word builder. Depends on ufg_pkg.
// A result appears in the output register in the cycle after its tick transfer.
// Throughput: one tick per cycle; input is held only while the output register is full
// and out_ready is low. The header checksum is computed and latched with the start command.
// Reset clears the control state and loads the configuration reset values; no clear pass.
module udp_frame_train_generator import ufg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [31:0]         stamp_seconds,
	input  logic [31:0]         stamp_nanoseconds,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [63:0]         data_word,
	output logic [7:0]          byte_keep,
	output logic                last_word,
	output logic [31:0]         packet_number
);

	logic [47:0] cfg_dmac_q, cfg_smac_q;
	logic [63:0] cfg_ip_q;
	logic [31:0] cfg_ports_q;
	logic [15:0] cfg_len_q;
	logic [26:0] cfg_ift_q;
	logic [31:0] cfg_count_q, cfg_gap_q;

	logic [47:0] trn_dmac_q, trn_smac_q;
	logic [63:0] trn_ip_q;
	logic [31:0] trn_ports_q;
	logic [15:0] trn_len_q;
	logic [26:0] trn_ift_q;
	logic [31:0] trn_count_q, trn_gap_q;
	logic [12:0] trn_last_idx_q;
	logic [7:0]  trn_keep_q;

	logic [31:0] stamp_sec_q, stamp_ns_q;
	logic [15:0] trn_csum_q;

	phase_t      phase_q, phase_d;
	logic [12:0] widx_q, widx_d;
	logic [31:0] pkt_q, pkt_d;
	logic [31:0] gap_q, gap_d;

	logic        out_valid_q;
	logic [63:0] data_q;
	logic [7:0]  keep_q;
	logic        last_q;
	logic [31:0] pnum_q;

	logic        in_fire, cfg_wr, start, emit, capture, is_last;
	logic [32:0] pkt_inc;
	logic [15:0] pad_len, cfg_tot, tot_len, udp_len, ident, csum_now;
	logic [2:0]  pad_rem;
	logic [19:0] hsum;
	logic [16:0] hfold;
	logic [7:0]  hb [64];
	logic [63:0] hdr_word, word_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dmac_q  <= '0;
			cfg_smac_q  <= '0;
			cfg_ip_q    <= '0;
			cfg_ports_q <= '0;
			cfg_len_q   <= MIN_FRAME_LEN;
			cfg_ift_q   <= 27'd64;
			cfg_count_q <= 32'd1;
			cfg_gap_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[5:3]))
				REG_DEST_MAC:     cfg_dmac_q  <= pwdata[47:0];
				REG_SRC_MAC:      cfg_smac_q  <= pwdata[47:0];
				REG_IP_ADDRESSES: cfg_ip_q    <= pwdata;
				REG_UDP_PORTS:    cfg_ports_q <= pwdata[31:0];
				REG_FRAME_LENGTH: cfg_len_q   <= pwdata[15:0];
				REG_ID_FLAGS_TTL: cfg_ift_q   <= pwdata[26:0];
				REG_PACKET_COUNT: cfg_count_q <= pwdata[31:0];
				REG_GAP_TICKS:    cfg_gap_q   <= pwdata[31:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[5:3]))
			REG_DEST_MAC:     prdata = {16'd0, cfg_dmac_q};
			REG_SRC_MAC:      prdata = {16'd0, cfg_smac_q};
			REG_IP_ADDRESSES: prdata = cfg_ip_q;
			REG_UDP_PORTS:    prdata = {32'd0, cfg_ports_q};
			REG_FRAME_LENGTH: prdata = {48'd0, cfg_len_q};
			REG_ID_FLAGS_TTL: prdata = {37'd0, cfg_ift_q};
			REG_PACKET_COUNT: prdata = {32'd0, cfg_count_q};
			REG_GAP_TICKS:    prdata = {32'd0, cfg_gap_q};
		endcase
	end

	assign pad_len = (cfg_len_q < MIN_FRAME_LEN) ? MIN_FRAME_LEN : cfg_len_q;
	assign pad_rem = pad_len[2:0];
	assign cfg_tot = pad_len - MAC_HDR_LEN;

	assign hsum = 20'({IP_VER_IHL, IP_TOS}) + 20'(cfg_tot) + 20'(cfg_ift_q[26:11])
		+ 20'({cfg_ift_q[10:8], 13'd0}) + 20'({cfg_ift_q[7:0], IP_PROTO_UDP})
		+ 20'(cfg_ip_q[63:48]) + 20'(cfg_ip_q[47:32])
		+ 20'(cfg_ip_q[31:16]) + 20'(cfg_ip_q[15:0]);
	assign hfold = 17'(hsum[19:16]) + 17'(hsum[15:0]);

	always_ff @(posedge clk) begin
		if (start) begin
			trn_dmac_q     <= cfg_dmac_q;
			trn_smac_q     <= cfg_smac_q;
			trn_ip_q       <= cfg_ip_q;
			trn_ports_q    <= cfg_ports_q;
			trn_len_q      <= pad_len;
			trn_ift_q      <= cfg_ift_q;
			trn_count_q    <= cfg_count_q;
			trn_gap_q      <= cfg_gap_q;
			trn_last_idx_q <= pad_len[15:3] - ((pad_rem == 3'd0) ? 13'd1 : 13'd0);
			trn_keep_q     <= (pad_rem == 3'd0) ? 8'hFF : 8'((9'd1 << pad_rem) - 9'd1);
			trn_csum_q     <= ~hfold[15:0];
		end
		if (capture) begin
			stamp_sec_q <= stamp_seconds;
			stamp_ns_q  <= stamp_nanoseconds;
		end
	end

	assign tot_len = trn_len_q - MAC_HDR_LEN;
	assign udp_len = trn_len_q - ALL_HDR_LEN;

	assign ident = trn_ift_q[26:11] + pkt_q[15:0];
	assign csum_now = trn_csum_q - pkt_q[15:0];

	always_comb begin
		for (int i = 0; i < 64; i++) begin
			hb[i] = 8'h00;
		end
		for (int i = 0; i < 6; i++) begin
			hb[i]     = trn_dmac_q[8*(5-i) +: 8];
			hb[6 + i] = trn_smac_q[8*(5-i) +: 8];
		end
		hb[12] = ETH_TYPE_IPV4[15:8];
		hb[13] = ETH_TYPE_IPV4[7:0];
		hb[14] = IP_VER_IHL;
		hb[15] = IP_TOS;
		hb[16] = tot_len[15:8];
		hb[17] = tot_len[7:0];
		hb[18] = ident[15:8];
		hb[19] = ident[7:0];
		hb[20] = {trn_ift_q[10:8], 5'd0};
		hb[22] = trn_ift_q[7:0];
		hb[23] = IP_PROTO_UDP;
		hb[24] = csum_now[15:8];
		hb[25] = csum_now[7:0];
		for (int i = 0; i < 4; i++) begin
			hb[26 + i] = trn_ip_q[32 + 8*(3-i) +: 8];
			hb[30 + i] = trn_ip_q[8*(3-i) +: 8];
			hb[34 + i] = trn_ports_q[8*(3-i) +: 8];
			hb[42 + i] = stamp_sec_q[8*(3-i) +: 8];
			hb[46 + i] = stamp_ns_q[8*(3-i) +: 8];
		end
		hb[38] = udp_len[15:8];
		hb[39] = udp_len[7:0];
		for (int k = 0; k < 8; k++) begin
			hdr_word[8*k +: 8] = hb[{widx_q[2:0], 3'(k)}];
		end
	end

	assign is_last = (widx_q == trn_last_idx_q);
	assign pkt_inc = {1'b0, pkt_q} + 33'd1;
	assign word_d = (widx_q < 13'(HDR_WORDS)) ? hdr_word : {45'd0, widx_q, 6'd0};

	always_comb begin
		phase_d = phase_q;
		widx_d  = widx_q;
		pkt_d   = pkt_q;
		gap_d   = gap_q;
		start   = 1'b0;
		emit    = 1'b0;
		capture = 1'b0;
		if (in_fire) begin
			if (command) begin
				start   = 1'b1;
				widx_d  = '0;
				pkt_d   = '0;
				gap_d   = '0;
				phase_d = (cfg_count_q != 32'd0) ? PH_SEND : PH_IDLE;
			end else begin
				unique case (phase_q)
					PH_GAP: begin
						if (gap_q != 32'd0) begin
							gap_d = gap_q - 32'd1;
						end
						if (gap_q[31:1] == 31'd0) begin
							phase_d = PH_SEND;
							widx_d  = '0;
						end
					end
					PH_SEND: begin
						emit    = 1'b1;
						capture = (widx_q == 13'd0);
						if (is_last) begin
							pkt_d  = pkt_inc[31:0];
							widx_d = '0;
							if (pkt_inc >= {1'b0, trn_count_q}) begin
								phase_d = PH_IDLE;
							end else if (trn_gap_q != 32'd0) begin
								phase_d = PH_GAP;
								gap_d   = trn_gap_q;
							end
						end else begin
							widx_d = widx_q + 13'd1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			widx_q      <= '0;
			pkt_q       <= '0;
			gap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			widx_q  <= widx_d;
			pkt_q   <= pkt_d;
			gap_q   <= gap_d;
			if (in_fire) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q <= word_d;
			keep_q <= is_last ? trn_keep_q : 8'hFF;
			last_q <= is_last;
			pnum_q <= pkt_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign data_word     = data_q;
	assign byte_keep     = keep_q;
	assign last_word     = last_q;
	assign packet_number = pnum_q;

`ifndef NO_ASSERTIONS
	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP |-> gap_q != 32'd0)
		else $error("Gap phase entered with a zero gap count.");

	a_widx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEND |-> widx_q <= trn_last_idx_q)
		else $error("Word index ran past the last word of the frame.");

	a_last_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !command && phase_q == PH_SEND && is_last |=> out_valid_q && last_q)
		else $error("Final word of a frame was not marked as last.");

	a_keep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> keep_q[0])
		else $error("Output word carries no valid byte.");
`endif

endmodule

// ===== bench/ufg_checker.sv =====
// Checker for the UDP frame train generator: follows register writes and both streams,
// predicts every output word and compares it field by field.
// Depends on ufg_pkg.
module ufg_checker import ufg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              command,
	input  logic [31:0]       stamp_seconds,
	input  logic [31:0]       stamp_nanoseconds,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [63:0]       data_word,
	input  logic [7:0]        byte_keep,
	input  logic              last_word,
	input  logic [31:0]       packet_number,
	output int                errors,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] data;
		logic [7:0]  keep;
		logic        last;
		logic [31:0] pnum;
	} bus_word_t;

	bus_word_t expected_words[$];
	bus_word_t oldest;

	logic [47:0] mac_dst, mac_src;
	logic [63:0] ip_pair;
	logic [31:0] port_pair;
	logic [15:0] len_cfg;
	logic [26:0] idft_cfg;
	logic [31:0] count_cfg, gap_cfg;

	logic [7:0]  hdr_bytes [64];
	logic [15:0] sum_base, ident_base;
	logic [12:0] word_idx;
	logic [31:0] frame_idx, gap_left, words_per_frame, frames_in_train, gap_len;
	logic [7:0]  keep_tail;
	phase_t      phase;

	task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
		errors++;
		if (errors <= 100)
			$display("%0t ns: %s got %h, expected %h", $realtime, field, got, want);
	endtask

	task automatic put_be(input int unsigned pos, input int unsigned nbytes,
			input logic [63:0] value);
		for (int i = 0; i < nbytes; i++)
			hdr_bytes[pos + i] = value[8*(nbytes-1-i) +: 8];
	endtask

	task automatic load_train();
		logic [15:0] len, tot, udp_len;
		logic [31:0] ip_s, ip_d, sum;
		logic [16:0] folded;
		len = (len_cfg < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len_cfg;
		tot = len - MAC_HDR_LEN;
		udp_len = len - ALL_HDR_LEN;
		ident_base = idft_cfg[26:11];
		ip_s = ip_pair[63:32];
		ip_d = ip_pair[31:0];
		foreach (hdr_bytes[i])
			hdr_bytes[i] = 8'h00;
		put_be(0, 6, mac_dst);
		put_be(6, 6, mac_src);
		put_be(12, 2, ETH_TYPE_IPV4);
		put_be(14, 2, {IP_VER_IHL, IP_TOS});
		put_be(16, 2, tot);
		put_be(18, 2, ident_base);
		put_be(20, 2, {idft_cfg[10:8], 13'd0});
		put_be(22, 2, {idft_cfg[7:0], IP_PROTO_UDP});
		put_be(26, 8, ip_pair);
		put_be(34, 4, port_pair);
		put_be(38, 2, udp_len);
		sum = {IP_VER_IHL, IP_TOS} + tot + ident_base + {idft_cfg[10:8], 13'd0}
			+ {idft_cfg[7:0], IP_PROTO_UDP} + ip_s[31:16] + ip_s[15:0]
			+ ip_d[31:16] + ip_d[15:0];
		folded = sum[31:16] + sum[15:0];
		sum_base = ~folded[15:0];
		words_per_frame = (32'(len) + 32'd7) >> 3;
		keep_tail = (len[2:0] != 3'd0) ? (8'd1 << len[2:0]) - 8'd1 : 8'hFF;
		frames_in_train = count_cfg;
		gap_len = gap_cfg;
		word_idx = '0;
		frame_idx = '0;
		gap_left = '0;
		phase = (count_cfg != 0) ? PH_SEND : PH_IDLE;
	endtask

	task automatic predict_tick(input logic [31:0] sec, input logic [31:0] nsec);
		bus_word_t w;
		if (phase == PH_GAP) begin
			if (gap_left != 0)
				gap_left = gap_left - 1;
			if (gap_left == 0) begin
				phase = PH_SEND;
				word_idx = '0;
			end
		end else if (phase == PH_SEND) begin
			if (word_idx == 0) begin
				put_be(42, 4, sec);
				put_be(46, 4, nsec);
				put_be(24, 2, sum_base - frame_idx[15:0]);
				put_be(18, 2, ident_base + frame_idx[15:0]);
			end
			if (word_idx < HDR_WORDS) begin
				for (int b = 0; b < 8; b++)
					w.data[8*b +: 8] = hdr_bytes[8*word_idx + b];
			end else begin
				w.data = 64'(word_idx) << 6;
			end
			w.last = (32'(word_idx) + 32'd1 >= words_per_frame);
			w.keep = w.last ? keep_tail : 8'hFF;
			w.pnum = frame_idx;
			expected_words.push_back(w);
			if (w.last) begin
				frame_idx = frame_idx + 1;
				word_idx = '0;
				if (frame_idx >= frames_in_train) begin
					phase = PH_IDLE;
				end else if (gap_len != 0) begin
					phase = PH_GAP;
					gap_left = gap_len;
				end
			end else begin
				word_idx = word_idx + 1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			mac_dst = '0;
			mac_src = '0;
			ip_pair = '0;
			port_pair = '0;
			len_cfg = MIN_FRAME_LEN;
			idft_cfg = 27'd64;
			count_cfg = 32'd1;
			gap_cfg = '0;
			foreach (hdr_bytes[i])
				hdr_bytes[i] = 8'h00;
			sum_base = '0;
			ident_base = '0;
			word_idx = '0;
			frame_idx = '0;
			gap_left = '0;
			words_per_frame = '0;
			frames_in_train = '0;
			gap_len = '0;
			keep_tail = '0;
			phase = PH_IDLE;
			expected_words.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_DEST_MAC:     mac_dst = pwdata[47:0];
					REG_SRC_MAC:      mac_src = pwdata[47:0];
					REG_IP_ADDRESSES: ip_pair = pwdata;
					REG_UDP_PORTS:    port_pair = pwdata[31:0];
					REG_FRAME_LENGTH: len_cfg = pwdata[15:0];
					REG_ID_FLAGS_TTL: idft_cfg = pwdata[26:0];
					REG_PACKET_COUNT: count_cfg = pwdata[31:0];
					REG_GAP_TICKS:    gap_cfg = pwdata[31:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report("data_word with no word expected", data_word, '0);
				end else begin
					oldest = expected_words.pop_front();
					if (data_word !== oldest.data)
						report("data_word", data_word, oldest.data);
					if (byte_keep !== oldest.keep)
						report("byte_keep", byte_keep, oldest.keep);
					if (last_word !== oldest.last)
						report("last_word", last_word, oldest.last);
					if (packet_number !== oldest.pnum)
						report("packet_number", packet_number, oldest.pnum);
				end
			end
			if (in_valid && in_ready) begin
				if (command)
					load_train();
				else
					predict_tick(stamp_seconds, stamp_nanoseconds);
			end
			outstanding <= expected_words.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the UDP frame train generator bench: clock, reset, register programming,
// start and tick stimulus with random idling on both streams, and the verdict.
// Depends on ufg_pkg, ufg_checker and udp_frame_train_generator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ufg_pkg::*;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_START = 1'b1;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned CALM_ITEMS = 150;
	localparam int unsigned HOLD_CYCLES = 120;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned TICK_CAP = 160;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic in_valid, in_ready, command;
	logic [31:0] stamp_seconds, stamp_nanoseconds;
	logic out_valid, out_ready;
	logic [63:0] data_word;
	logic [7:0] byte_keep;
	logic last_word;
	logic [31:0] packet_number;
	int errors, outstanding;

	int unsigned cycles = 0;
	int unsigned sent;
	int unsigned stall_pct, gap_pct;
	bit calm, want_hold, held, paused;
	logic [15:0] len_shadow;
	logic [31:0] count_shadow, gap_shadow;

	udp_frame_train_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.stamp_seconds(stamp_seconds), .stamp_nanoseconds(stamp_nanoseconds),
		.out_valid(out_valid), .out_ready(out_ready), .data_word(data_word),
		.byte_keep(byte_keep), .last_word(last_word), .packet_number(packet_number)
	);

	ufg_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.stamp_seconds(stamp_seconds), .stamp_nanoseconds(stamp_nanoseconds),
		.out_valid(out_valid), .out_ready(out_ready), .data_word(data_word),
		.byte_keep(byte_keep), .last_word(last_word), .packet_number(packet_number),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (want_hold && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(99, 0) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(11, 1)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] pick_value(input int unsigned bits);
		logic [63:0] mask;
		mask = (bits >= 64) ? '1 : (64'd1 << bits) - 64'd1;
		case ($urandom_range(7, 0))
			0: return '0;
			1: return mask;
			default: return {$urandom(), $urandom()} & mask;
		endcase
	endfunction

	task automatic wr_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FRAME_LENGTH: len_shadow = value[15:0];
			REG_PACKET_COUNT: count_shadow = value[31:0];
			REG_GAP_TICKS:    gap_shadow = value[31:0];
			default: ;
		endcase
	endtask

	task automatic transfer(input logic cmd, input logic [31:0] sec, input logic [31:0] nsec);
		in_valid <= 1'b1;
		command <= cmd;
		stamp_seconds <= sec;
		stamp_nanoseconds <= nsec;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (!calm && $urandom_range(99, 0) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(11, 1)) @(posedge clk);
		end
	endtask

	task automatic drain(input int unsigned extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned ticks, phase_no;
		longint unsigned full;
		logic [15:0] len_eff;
		logic [31:0] wpf;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		stamp_seconds <= '0;
		stamp_nanoseconds <= '0;
		calm = 1'b0;
		want_hold = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		stall_pct = 25;
		gap_pct = 25;
		sent = 0;
		len_shadow = MIN_FRAME_LEN;
		count_shadow = 32'd1;
		gap_shadow = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: a start, a restart inside the first frame, then one whole frame.
		transfer(CMD_START, $urandom(), $urandom());
		repeat (4) transfer(CMD_TICK, $urandom(), $urandom());
		transfer(CMD_START, $urandom(), $urandom());
		transfer(CMD_TICK, '1, '1);
		repeat (8) transfer(CMD_TICK, $urandom(), $urandom());
		drain(4);

		wr_reg(REG_DEST_MAC, '1);
		wr_reg(REG_SRC_MAC, '1);
		wr_reg(REG_IP_ADDRESSES, '1);
		wr_reg(REG_UDP_PORTS, '1);
		wr_reg(REG_FRAME_LENGTH, 64'd61);
		wr_reg(REG_ID_FLAGS_TTL, '1);
		wr_reg(REG_PACKET_COUNT, 64'd1);
		wr_reg(REG_GAP_TICKS, '1);
		transfer(CMD_START, $urandom(), $urandom());
		transfer(CMD_TICK, '0, '0);
		repeat (8) transfer(CMD_TICK, $urandom(), $urandom());
		drain(4);

		// The first words of a frame of the largest length; the next start cuts it off.
		wr_reg(REG_FRAME_LENGTH, 64'd65535);
		wr_reg(REG_GAP_TICKS, '0);
		transfer(CMD_START, $urandom(), $urandom());
		repeat (200) transfer(CMD_TICK, $urandom(), $urandom());
		drain(4);

		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(1, 0)) wr_reg(REG_DEST_MAC, pick_value(48));
			if ($urandom_range(1, 0)) wr_reg(REG_SRC_MAC, pick_value(48));
			if ($urandom_range(1, 0)) wr_reg(REG_IP_ADDRESSES, pick_value(64));
			if ($urandom_range(1, 0)) wr_reg(REG_UDP_PORTS, pick_value(32));
			if ($urandom_range(1, 0)) wr_reg(REG_ID_FLAGS_TTL, pick_value(27));
			if ($urandom_range(3, 0) != 0) begin
				case ($urandom_range(9, 0))
					0: wr_reg(REG_FRAME_LENGTH, 64'($urandom_range(59, 0)));
					1: wr_reg(REG_FRAME_LENGTH, 64'(MIN_FRAME_LEN));
					2: wr_reg(REG_FRAME_LENGTH, 64'($urandom_range(68, 61)));
					3: wr_reg(REG_FRAME_LENGTH, '0);
					default: wr_reg(REG_FRAME_LENGTH, 64'($urandom_range(200, 60)));
				endcase
			end
			if ($urandom_range(3, 0) != 0) begin
				case ($urandom_range(9, 0))
					0: wr_reg(REG_PACKET_COUNT, '0);
					1: wr_reg(REG_PACKET_COUNT, 64'h0000_0000_FFFF_FFFF);
					default: wr_reg(REG_PACKET_COUNT, 64'($urandom_range(4, 1)));
				endcase
			end
			if ($urandom_range(3, 0) != 0) begin
				case ($urandom_range(9, 0))
					0: wr_reg(REG_GAP_TICKS, 64'h0000_0000_FFFF_FFFF);
					1, 2, 3, 4: wr_reg(REG_GAP_TICKS, '0);
					default: wr_reg(REG_GAP_TICKS, 64'($urandom_range(3, 1)));
				endcase
			end
			if (phase_no == 2) begin
				wr_reg(REG_FRAME_LENGTH, 64'd160);
				wr_reg(REG_PACKET_COUNT, 64'd3);
				wr_reg(REG_GAP_TICKS, 64'd2);
			end

			len_eff = (len_shadow < MIN_FRAME_LEN) ? MIN_FRAME_LEN : len_shadow;
			wpf = (32'(len_eff) + 32'd7) >> 3;
			if (count_shadow == 0) begin
				ticks = $urandom_range(5, 1);
			end else begin
				full = 64'(count_shadow) * wpf + (64'(count_shadow) - 1) * gap_shadow;
				ticks = (full > TICK_CAP) ? TICK_CAP : int'(full);
				ticks = ticks + $urandom_range(3, 0);
			end
			if (phase_no != 2 && $urandom_range(5, 0) == 0)
				ticks = $urandom_range(ticks, 1);
			case ($urandom_range(2, 0))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 40;
			endcase
			case ($urandom_range(2, 0))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase

			transfer(CMD_START, $urandom(), $urandom());
			for (int i = 0; i < ticks; i++) begin
				calm = (sent + CALM_ITEMS >= RANDOM_ITEMS);
				if (phase_no == 2 && i == 5)
					want_hold = 1'b1;
				if (phase_no >= 4 && !paused && i == ticks / 2) begin
					paused = 1'b1;
					drain(0);
				end
				transfer(($urandom_range(59, 0) == 0) ? CMD_START : CMD_TICK,
					$urandom(), $urandom());
			end
			drain(4);
			phase_no++;
		end

		drain(10);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
